FILE: rtl/core/jls_pkg.sv
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types, constants and helpers for the Jacobi Laplace solver.
// ----------------------------------------------------------------------------
package jls_pkg;

  localparam int GRID_MAX  = 64;
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 24;
  localparam int IDX_W     = 7;
  localparam int ADDR_W    = $clog2(GRID_MAX);
  localparam int STEP_W    = $clog2(GRID_MAX + 4);
  localparam int CNT_W     = 20;
  localparam int CI_W      = 16;
  localparam int REG_IDX_W = 2;
  localparam int BV_W      = IDX_W + FRAC_BITS + 1;

  localparam logic [REG_IDX_W-1:0] REG_GRID_SIZE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_CHECK_INTVL = 2'd3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0] cell_value;
    logic [CNT_W-1:0] sweep_count;
    logic             converged;
  } out_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              win_clr;
    logic              feed_v;
    logic              feed_bot;
    logic              cmp_v;
    logic              wr_en;
    logic              wr_zero;
    logic [ADDR_W-1:0] wr_addr;
  } cell_ctl_t;

  // Fixed boundary value idx << FRAC_BITS, saturated to VAL_W bits.
  function automatic logic [VAL_W-1:0] boundary_value(input logic [IDX_W-1:0] idx);
    logic [BV_W-1:0] v;
    v = BV_W'(idx) << FRAC_BITS;
    if (v > BV_W'({VAL_W{1'b1}})) begin
      return {VAL_W{1'b1}};
    end
    return v[VAL_W-1:0];
  endfunction

endpackage

FILE: rtl/core/jls_cell.sv
// ----------------------------------------------------------------------------
// jls_cell
// One grid column: column memory, 3-row window and stencil update.
// ----------------------------------------------------------------------------
module jls_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  jls_pkg::cell_ctl_t        ctl,
  input  logic [jls_pkg::VAL_W-1:0] tol,
  input  logic                      active,
  input  logic [jls_pkg::VAL_W-1:0] bot_val,
  input  logic [jls_pkg::VAL_W-1:0] left_in,
  input  logic [jls_pkg::VAL_W-1:0] right_in,
  output logic [jls_pkg::VAL_W-1:0] mid_out,
  output logic [jls_pkg::VAL_W-1:0] rd_data,
  output logic                      ok,
  output logic                      ch
);

  logic [jls_pkg::VAL_W-1:0] mem [jls_pkg::GRID_MAX];
  logic [jls_pkg::VAL_W-1:0] rdata_r;
  logic [jls_pkg::VAL_W-1:0] up_r, mid_r, dn_r;
  logic [jls_pkg::VAL_W-1:0] nv_r;
  logic                      ok_r, ch_r;
  logic [jls_pkg::VAL_W+1:0] sum;
  logic [jls_pkg::VAL_W-1:0] nv, diff;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_zero ? '0 : nv_r;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[ctl.rd_addr];
    end
  end

  // Window: up/mid/dn hold old rows r-1, r, r+1.
  always_ff @(posedge clk) begin
    if (ctl.win_clr) begin
      dn_r <= '0;
    end else if (ctl.feed_v) begin
      up_r  <= mid_r;
      mid_r <= dn_r;
      dn_r  <= ctl.feed_bot ? bot_val : rdata_r;
    end
  end

  always_comb begin
    sum = (jls_pkg::VAL_W+2)'(up_r) + (jls_pkg::VAL_W+2)'(dn_r)
        + (jls_pkg::VAL_W+2)'(left_in) + (jls_pkg::VAL_W+2)'(right_in);
    nv   = sum[jls_pkg::VAL_W+1:2];
    diff = (nv >= mid_r) ? (nv - mid_r) : (mid_r - nv);
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_v) begin
      nv_r <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b1;
      ch_r <= 1'b0;
    end else begin
      ok_r <= !(ctl.cmp_v && active) || (diff <= tol);
      ch_r <= ctl.cmp_v && active && (diff != '0);
    end
  end

  assign mid_out = mid_r;
  assign rd_data = rdata_r;
  assign ok      = ok_r;
  assign ch      = ch_r;

endmodule

FILE: rtl/core/jls_ctrl.sv
// ----------------------------------------------------------------------------
// jls_ctrl
// Sequencer: config registers, clear pass, sweep timing, stop decision,
// read decode and result register.
// ----------------------------------------------------------------------------
module jls_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jls_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jls_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [jls_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [jls_pkg::VAL_W-1:0]     cfg_wdata,
  output jls_pkg::cell_ctl_t            cell_ctl,
  output logic [jls_pkg::IDX_W-1:0]     n_out,
  output logic [jls_pkg::VAL_W-1:0]     tol_out,
  output logic [jls_pkg::VAL_W-1:0]     bv_row,
  output logic [jls_pkg::ADDR_W-1:0]    rd_sel,
  input  logic [jls_pkg::VAL_W-1:0]     rd_val,
  input  logic                          all_ok,
  input  logic                          any_ch
);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CLR, S_SWP, S_FIN, S_PUSH} state_t;
  typedef enum logic [1:0] {RC_ZERO, RC_MEM, RC_BV} rcls_t;

  state_t                        state_r;
  logic [jls_pkg::STEP_W-1:0]    cnt_r;
  logic [jls_pkg::IDX_W-1:0]     n_r, gs_r;
  logic [jls_pkg::VAL_W-1:0]     tol_r;
  logic [jls_pkg::CNT_W-1:0]     lim_r, k_r, sweeps_r;
  logic [jls_pkg::CI_W-1:0]      ci_r, ph_r;
  logic                          started_r, ok_acc_r, ch_acc_r, conv_r;
  logic [jls_pkg::VAL_W-1:0]     res_val_r, bv_r;
  rcls_t                         rcls_r;
  logic [jls_pkg::ADDR_W-1:0]    rsel_r;
  logic                          out_valid_r;
  jls_pkg::out_t                 out_data_r;

  logic                          in_xfer;
  logic [jls_pkg::IDX_W-1:0]     n_clamp, n1, rr, cc;
  logic                          r_in, c_in;
  logic [jls_pkg::STEP_W-1:0]    n_s;
  logic [jls_pkg::CNT_W-1:0]     kn;
  logic [jls_pkg::CI_W-1:0]      phn;
  logic                          mult;
  logic [jls_pkg::CNT_W:0]       m_jump;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign rr       = in_data.row_index;
  assign cc       = in_data.col_index;
  assign n1       = n_r + 1'b1;
  assign r_in     = (rr != '0) && (rr <= n_r);
  assign c_in     = (cc != '0) && (cc <= n_r);
  assign n_s      = jls_pkg::STEP_W'(n_r);

  always_comb begin
    if (gs_r == '0) begin
      n_clamp = jls_pkg::IDX_W'(1);
    end else if (gs_r > jls_pkg::IDX_W'(jls_pkg::GRID_MAX)) begin
      n_clamp = jls_pkg::IDX_W'(jls_pkg::GRID_MAX);
    end else begin
      n_clamp = gs_r;
    end
  end

  // Stop decision inputs for the sweep just finished.
  assign kn     = k_r + 1'b1;
  assign phn    = ph_r + 1'b1;
  assign mult   = (ci_r != '0) && (phn == ci_r);
  assign m_jump = (jls_pkg::CNT_W+1)'(kn) + (jls_pkg::CNT_W+1)'(ci_r)
                - (jls_pkg::CNT_W+1)'(phn);

  // Sweep step s: read row s+1, feed rows 1..n+1, compute rows at s-2,
  // write back at s-4 (addresses are row-1).
  always_comb begin
    cell_ctl = '0;
    bv_row   = jls_pkg::boundary_value(jls_pkg::IDX_W'(cnt_r - 2'd2));
    unique case (state_r)
      S_IDLE: begin
        cell_ctl.rd_en   = in_xfer && (in_data.req_type == jls_pkg::REQ_READ);
        cell_ctl.rd_addr = jls_pkg::ADDR_W'(rr - 1'b1);
      end
      S_CLR: begin
        cell_ctl.wr_en   = 1'b1;
        cell_ctl.wr_zero = 1'b1;
        cell_ctl.wr_addr = cnt_r[jls_pkg::ADDR_W-1:0];
      end
      S_SWP: begin
        cell_ctl.rd_en    = cnt_r < n_s;
        cell_ctl.rd_addr  = cnt_r[jls_pkg::ADDR_W-1:0];
        cell_ctl.win_clr  = cnt_r == '0;
        cell_ctl.feed_v   = (cnt_r >= 1) && (cnt_r <= n_s + 1'b1);
        cell_ctl.feed_bot = cnt_r == n_s + 1'b1;
        cell_ctl.cmp_v    = (cnt_r >= 3) && (cnt_r <= n_s + 2'd2);
        cell_ctl.wr_en    = (cnt_r >= 4) && (cnt_r <= n_s + 2'd3);
        cell_ctl.wr_addr  = jls_pkg::ADDR_W'(cnt_r - 3'd4);
      end
      default: begin
        cell_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      n_r         <= jls_pkg::IDX_W'(jls_pkg::GRID_MAX);
      gs_r        <= 7'd64;
      tol_r       <= 24'd66;
      lim_r       <= 20'd500000;
      ci_r        <= 16'd100;
      k_r         <= '0;
      ph_r        <= '0;
      sweeps_r    <= '0;
      conv_r      <= 1'b0;
      started_r   <= 1'b0;
      ok_acc_r    <= 1'b1;
      ch_acc_r    <= 1'b0;
      rcls_r      <= RC_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          jls_pkg::REG_GRID_SIZE:   gs_r  <= cfg_wdata[jls_pkg::IDX_W-1:0];
          jls_pkg::REG_TOLERANCE:   tol_r <= cfg_wdata;
          jls_pkg::REG_ITER_LIMIT:  lim_r <= cfg_wdata[jls_pkg::CNT_W-1:0];
          jls_pkg::REG_CHECK_INTVL: ci_r  <= cfg_wdata[jls_pkg::CI_W-1:0];
          default: ;
        endcase
      end
      // S_PUSH reloads the result register itself.
      if (out_valid_r && out_ready && (state_r != S_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data.req_type == jls_pkg::REQ_START) begin
              n_r       <= n_clamp;
              started_r <= 1'b1;
              cnt_r     <= '0;
              state_r   <= S_CLR;
            end else begin
              rsel_r <= jls_pkg::ADDR_W'(cc - 1'b1);
              if (!started_r) begin
                rcls_r <= RC_ZERO;
              end else if (r_in && c_in) begin
                rcls_r <= RC_MEM;
              end else if ((rr == n1) && c_in) begin
                rcls_r <= RC_BV;
                bv_r   <= jls_pkg::boundary_value(cc);
              end else if ((cc == n1) && r_in) begin
                rcls_r <= RC_BV;
                bv_r   <= jls_pkg::boundary_value(rr);
              end else begin
                rcls_r <= RC_ZERO;
              end
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          case (rcls_r)
            RC_MEM:  res_val_r <= rd_val;
            RC_BV:   res_val_r <= bv_r;
            default: res_val_r <= '0;
          endcase
          state_r <= S_PUSH;
        end
        S_CLR: begin
          if (cnt_r == jls_pkg::STEP_W'(jls_pkg::GRID_MAX - 1)) begin
            cnt_r    <= '0;
            k_r      <= '0;
            ph_r     <= '0;
            ok_acc_r <= 1'b1;
            ch_acc_r <= 1'b0;
            state_r  <= S_SWP;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SWP: begin
          ok_acc_r <= ok_acc_r && all_ok;
          ch_acc_r <= ch_acc_r || any_ch;
          if (cnt_r == n_s + 2'd3) begin
            cnt_r   <= '0;
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_FIN: begin
          res_val_r <= '0;
          if (mult && ok_acc_r) begin
            sweeps_r <= kn;
            conv_r   <= 1'b1;
            state_r  <= S_PUSH;
          end else if (kn >= lim_r) begin
            sweeps_r <= kn;
            conv_r   <= 1'b0;
            state_r  <= S_PUSH;
          end else if (!ch_acc_r) begin
            // settled grid: later sweeps repeat, jump to next test or limit
            if ((ci_r != '0) && (m_jump <= (jls_pkg::CNT_W+1)'(lim_r))) begin
              sweeps_r <= m_jump[jls_pkg::CNT_W-1:0];
              conv_r   <= 1'b1;
            end else begin
              sweeps_r <= lim_r;
              conv_r   <= 1'b0;
            end
            state_r <= S_PUSH;
          end else begin
            k_r      <= kn;
            ph_r     <= mult ? '0 : phn;
            ok_acc_r <= 1'b1;
            ch_acc_r <= 1'b0;
            state_r  <= S_SWP;
          end
        end
        S_PUSH: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.cell_value  <= res_val_r;
            out_data_r.sweep_count <= sweeps_r;
            out_data_r.converged   <= conv_r;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign n_out     = n_r;
  assign tol_out   = tol_r;
  assign rd_sel    = rsel_r;

`ifndef NO_ASSERTIONS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_ctl.rd_en && cell_ctl.wr_en) |-> (cell_ctl.rd_addr != cell_ctl.wr_addr))
    else $error("row read and write-back hit the same address");
  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.req_type == jls_pkg::REQ_START)) |=> (state_r == S_CLR))
    else $error("start transfer did not enter clear pass");
  a_acc_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWP && cnt_r == '0) |-> (ok_acc_r && !ch_acc_r))
    else $error("sweep flags not reset at sweep start");
`endif

endmodule

FILE: rtl/core/jacobi_laplace_solver.sv
// ----------------------------------------------------------------------------
// jacobi_laplace_solver
// Jacobi 5-point Laplace solver on an up to 64x64 unsigned Q8.16 grid.
// ----------------------------------------------------------------------------
// A start transfer zeroes the column memories, then runs sweeps over the grid
// (n = grid_size clamped to 1..64) until the tolerance test passes on a
// check_interval multiple, the grid stops changing, or the iteration limit
// is reached; one result transfer then reports the sweep count and
// converged flag. A read transfer returns one cell via memory read, column
// select and result register. Cells outside the last solve's grid read
// zero, except its bottom and right boundary cells, which read their
// boundary value; all cells before the first start read zero. The grid is
// a chain of 64 column cells; each holds its column in a small memory and
// keeps a three-row window, handing its center row to both neighbors every
// cycle, so a whole row is updated per cycle and written back in place.
// ----------------------------------------------------------------------------
module jacobi_laplace_solver (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  jls_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output jls_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [jls_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [jls_pkg::VAL_W-1:0]     cfg_wdata
);

  jls_pkg::cell_ctl_t          cell_ctl;
  logic [jls_pkg::IDX_W-1:0]   n;
  logic [jls_pkg::VAL_W-1:0]   tol, bv_row, rd_val;
  logic [jls_pkg::ADDR_W-1:0]  rd_sel;
  logic [jls_pkg::VAL_W-1:0]   mid   [jls_pkg::GRID_MAX];
  logic [jls_pkg::VAL_W-1:0]   rdata [jls_pkg::GRID_MAX];
  logic [jls_pkg::GRID_MAX-1:0] ok_vec, ch_vec;

  jls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cell_ctl  (cell_ctl),
    .n_out     (n),
    .tol_out   (tol),
    .bv_row    (bv_row),
    .rd_sel    (rd_sel),
    .rd_val    (rd_val),
    .all_ok    (&ok_vec),
    .any_ch    (|ch_vec)
  );

  // Column chain. Left of column 1 is the zero boundary; right of column n
  // is the right boundary, equal to the row index.
  for (genvar g = 0; g < jls_pkg::GRID_MAX; g++) begin : g_col
    logic [jls_pkg::VAL_W-1:0] left_v, right_v, right_nb;
    logic                      last;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = mid[g-1];
    end
    if (g == jls_pkg::GRID_MAX - 1) begin : g_end
      assign right_nb = '0;
    end else begin : g_nb
      assign right_nb = mid[g+1];
    end
    assign last    = (n == jls_pkg::IDX_W'(g + 1));
    assign right_v = last ? bv_row : right_nb;

    jls_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .tol      (tol),
      .active   (jls_pkg::IDX_W'(g + 1) <= n),
      .bot_val  (jls_pkg::boundary_value(jls_pkg::IDX_W'(g + 1))),
      .left_in  (left_v),
      .right_in (right_v),
      .mid_out  (mid[g]),
      .rd_data  (rdata[g]),
      .ok       (ok_vec[g]),
      .ch       (ch_vec[g])
    );
  end

  // Read transfer: pick the requested column's registered memory word.
  assign rd_val = rdata[rd_sel];

endmodule

FILE: sim/tb_jacobi_laplace_solver.sv
// ----------------------------------------------------------------------------
// tb_jacobi_laplace_solver
// Self-checking bench for the Jacobi Laplace solver: start and read transfers
// are predicted by a local grid model and compared with every result.
// ----------------------------------------------------------------------------
module tb_jacobi_laplace_solver;
  timeunit 1ns;
  timeprecision 1ps;

  import jls_pkg::*;

  localparam int DIM       = GRID_MAX + 2;
  localparam int CYC_LIMIT = 4000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0]     cfg_wdata;

  jacobi_laplace_solver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Local copy of both grids, solve status and register shadows.
  logic [VAL_W-1:0] grid_buf [2][DIM*DIM];
  logic             newest_sel;
  logic [CNT_W-1:0] last_sweeps;
  logic             last_conv;
  logic [IDX_W-1:0] sh_size;
  logic [VAL_W-1:0] sh_tol;
  logic [CNT_W-1:0] sh_limit;
  logic [CI_W-1:0]  sh_interval;

  out_t expected_q[$];
  bit   failed;
  int   cycles;
  int   burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a runaway solve ends the run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("tb_jacobi_laplace_solver failed");
      $finish;
    end
  end

  // Receiver stall pattern from a randomly re-rolled mode; one mode never stalls.
  int stall_mode;
  always @(posedge clk) begin
    if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= $urandom_range(0, 1);
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  // Result checker: each result transfer pops the oldest expectation.
  always @(posedge clk) begin
    out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_data);
        failed = 1'b1;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.cell_value !== exp_r.cell_value) begin
          $error("cell_value expected %h actual %h", exp_r.cell_value, out_data.cell_value);
          failed = 1'b1;
        end
        if (out_data.sweep_count !== exp_r.sweep_count) begin
          $error("sweep_count expected %0d actual %0d",
                 exp_r.sweep_count, out_data.sweep_count);
          failed = 1'b1;
        end
        if (out_data.converged !== exp_r.converged) begin
          $error("converged expected %0d actual %0d", exp_r.converged, out_data.converged);
          failed = 1'b1;
        end
      end
    end
  end

  function automatic logic [VAL_W-1:0] edge_value(int idx);
    longint v;
    v = longint'(idx) << FRAC_BITS;
    return (v > 64'hFFFFFF) ? {VAL_W{1'b1}} : v[VAL_W-1:0];
  endfunction

  // Full solve: clear, set boundaries, sweep until tolerance, settle or limit.
  task automatic run_solve();
    int          n;
    int unsigned k, lim, ci, m;
    bit          conv, ok, changed;
    int          src, dst, p;
    logic [VAL_W+1:0] sum;
    logic [VAL_W-1:0] nv, ov, d;
    n = sh_size;
    if (n < 1) n = 1;
    if (n > GRID_MAX) n = GRID_MAX;
    lim  = sh_limit;
    ci   = sh_interval;
    k    = 0;
    conv = 1'b0;
    for (int g = 0; g < 2; g++) begin
      for (int q = 0; q < DIM*DIM; q++) grid_buf[g][q] = '0;
      for (int i = 1; i <= n; i++) begin
        grid_buf[g][(n+1)*DIM + i] = edge_value(i);
        grid_buf[g][i*DIM + n + 1] = edge_value(i);
      end
    end
    newest_sel = 1'b0;
    forever begin
      k++;
      src = newest_sel;
      dst = !newest_sel;
      ok = 1'b1;
      changed = 1'b0;
      for (int i = 1; i <= n; i++) begin
        for (int j = 1; j <= n; j++) begin
          p   = i*DIM + j;
          sum = grid_buf[src][p-DIM] + grid_buf[src][p+DIM]
              + grid_buf[src][p-1] + grid_buf[src][p+1];
          nv  = sum[VAL_W+1:2];
          ov  = grid_buf[src][p];
          d   = (nv >= ov) ? nv - ov : ov - nv;
          if (d > sh_tol) ok = 1'b0;
          if (d != 0) changed = 1'b1;
          grid_buf[dst][p] = nv;
        end
      end
      newest_sel = !newest_sel;
      if (ci != 0 && (k % ci) == 0 && ok) begin
        conv = 1'b1;
        break;
      end
      if (k >= lim) begin
        conv = 1'b0;
        break;
      end
      // Settled grid: later sweeps repeat, jump to the next test or the limit.
      if (!changed) begin
        if (ci == 0) begin
          k = lim;
          conv = 1'b0;
        end else begin
          m = (k / ci + 1) * ci;
          if (m <= lim) begin
            k = m;
            conv = 1'b1;
          end else begin
            k = lim;
            conv = 1'b0;
          end
        end
        break;
      end
    end
    last_sweeps = k[CNT_W-1:0];
    last_conv   = conv;
  endtask

  function automatic out_t predict_result(in_t req);
    out_t r;
    r.cell_value = '0;
    if (req.req_type == REQ_READ && req.row_index < DIM && req.col_index < DIM)
      r.cell_value = grid_buf[newest_sel][req.row_index*DIM + req.col_index];
    r.sweep_count = last_sweeps;
    r.converged   = last_conv;
    return r;
  endfunction

  // One input transfer; valid stays high afterward unless a gap follows.
  task automatic send_item(in_t req);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    if (req.req_type == REQ_START) run_solve();
    expected_q.push_back(predict_result(req));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write enable is left high; the caller drops it after the last write.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GRID_SIZE:  sh_size     = val[IDX_W-1:0];
      REG_TOLERANCE:  sh_tol      = val;
      REG_ITER_LIMIT: sh_limit    = val[CNT_W-1:0];
      default:        sh_interval = val[CI_W-1:0];
    endcase
  endtask

  task automatic set_config(int sz, int tol, int lim, int ci);
    drain();
    write_reg(REG_GRID_SIZE, VAL_W'(sz));
    write_reg(REG_TOLERANCE, VAL_W'(tol));
    write_reg(REG_ITER_LIMIT, VAL_W'(lim));
    write_reg(REG_CHECK_INTVL, VAL_W'(ci));
    cfg_we <= 1'b0;
  endtask

  task automatic send_req(logic kind, int row, int col);
    in_t req;
    req.req_type  = kind;
    req.row_index = IDX_W'(row);
    req.col_index = IDX_W'(col);
    send_item(req);
  endtask

  // Reads before the first start, which all return zero.
  task automatic test_read_before_start();
    send_req(REQ_READ, 0, 0);
    send_req(REQ_READ, 1, 1);
    send_req(REQ_READ, 127, 127);
  endtask

  // Register extremes and the clamping and degenerate-setting cases.
  task automatic test_directed();
    set_config(1, 0, 20'hFFFFF, 1);       // tiny grid settles and passes the test
    send_req(REQ_START, 0, 0);
    send_req(REQ_READ, 1, 1);
    send_req(REQ_READ, 2, 1);
    send_req(REQ_READ, 1, 2);
    send_req(REQ_READ, 2, 2);
    set_config(0, 24'hFFFFFF, 1, 65535);  // size zero taken as one
    send_req(REQ_START, 5, 9);
    send_req(REQ_READ, 1, 1);
    set_config(127, 0, 3, 0);             // oversize clamped, test disabled
    send_req(REQ_START, 127, 0);
    send_req(REQ_READ, 64, 65);
    send_req(REQ_READ, 65, 64);
    send_req(REQ_READ, 66, 3);
    send_req(REQ_READ, 3, 127);
    set_config(4, 24'hFFFFFF, 0, 1);      // limit zero, converges at sweep one
    send_req(REQ_START, 0, 0);
    send_req(REQ_READ, 5, 2);
    set_config(8, 100, 1000, 0);          // interval zero runs to limit or settle
    send_req(REQ_START, 0, 0);
    send_req(REQ_READ, 4, 4);
    set_config(64, 66, 40, 20);
    send_req(REQ_START, 0, 0);
    send_req(REQ_READ, 64, 64);
    send_req(REQ_READ, 32, 1);
  endtask

  // Random configurations and mostly reads inside the last solved grid.
  task automatic test_random(int count);
    int n, tol, lim, ci, row, col, pick;
    for (int it = 0; it < count; it++) begin
      if ($urandom_range(0, 99) < 5) begin
        if ($urandom_range(0, 2) != 0) begin
          pick = $urandom_range(0, 19);
          n    = (pick < 16) ? $urandom_range(1, 8) :
                 (pick < 19) ? $urandom_range(9, 24) : 64;
          pick = $urandom_range(0, 3);
          tol  = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 2000) :
                 (pick == 2) ? 24'hFFFFFF : $urandom_range(0, 24'hFFFFFF);
          if (n <= 8 && $urandom_range(0, 2) == 0)
            lim = $urandom_range(0, 20'hFFFFF);
          else
            lim = $urandom_range(0, (n > 24) ? 20 : 60);
          pick = $urandom_range(0, 9);
          ci   = (pick == 0) ? 0 : (pick == 1) ? 65535 :
                 (pick == 2) ? $urandom_range(0, 65535) : $urandom_range(1, 12);
          set_config(n, tol, lim, ci);
        end
        send_req(REQ_START, $urandom_range(0, 127), $urandom_range(0, 127));
      end else begin
        n = (sh_size < 1) ? 1 : (sh_size > GRID_MAX) ? GRID_MAX : sh_size;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          row = $urandom_range(0, n + 1);
          col = $urandom_range(0, n + 1);
        end else if (pick < 9) begin
          row = $urandom_range(0, DIM - 1);
          col = $urandom_range(0, DIM - 1);
        end else begin
          row = $urandom_range(0, 127);
          col = $urandom_range(0, 127);
        end
        send_req(REQ_READ, row, col);
      end
    end
  endtask

  initial begin
    failed     = 1'b0;
    cycles     = 0;
    burst_left = 0;
    stall_mode = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_GRID_SIZE;
    cfg_wdata  = '0;
    // Shadows follow the register reset values; grids start all zero.
    sh_size     = 64;
    sh_tol      = 66;
    sh_limit    = 500000;
    sh_interval = 100;
    newest_sel  = 1'b0;
    last_sweeps = '0;
    last_conv   = 1'b0;
    for (int g = 0; g < 2; g++)
      for (int q = 0; q < DIM*DIM; q++) grid_buf[g][q] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_read_before_start();
    test_directed();
    set_config(3, 50, 30, 2);
    send_req(REQ_START, 0, 0);
    test_random(1625);

    drain();
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("tb_jacobi_laplace_solver passed");
    end else begin
      $display("tb_jacobi_laplace_solver failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/jls_pkg.sv
rtl/core/jls_cell.sv
rtl/core/jls_ctrl.sv
rtl/core/jacobi_laplace_solver.sv
sim/tb_jacobi_laplace_solver.sv
